/* design/chbf_pkg.sv */
// Shared constants and types for the command hash bitmap filter.
// No dependencies; compile first.
package chbf_pkg;

  // Bitmap geometry: power-of-two size, stored as rows of 32-bit words.
  localparam int BITMAP_BITS = 8192;
  localparam int HASH_W      = $clog2(BITMAP_BITS);
  localparam int WORD_W      = 32;
  localparam int OFF_W       = $clog2(WORD_W);
  localparam int ROWS        = BITMAP_BITS / WORD_W;
  localparam int ROW_W       = $clog2(ROWS);

  // Hash multiplier and its square, both reduced modulo the bitmap size.
  localparam int HASH_MUL    = 243;
  localparam int HASH_MUL_SQ = (HASH_MUL * HASH_MUL) % BITMAP_BITS;

  // Field widths.
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 16;
  localparam int DIR_W       = 6;
  localparam int MAX_DIRS    = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

endpackage

/* design/chbf_if.sv */
// Valid/ready channel interfaces for the filter's item and result streams.
// Depends on chbf_pkg.
interface chbf_in_if import chbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic                name_end;
  logic [DIR_W-1:0]    dir_index;

  modport source (output valid, action, char_code, name_end, dir_index, input ready);
  modport sink   (input valid, action, char_code, name_end, dir_index, output ready);
endinterface

interface chbf_out_if ();
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, maybe_present, input ready);
  modport sink   (input valid, maybe_present, output ready);
endinterface

/* design/command_hash_bitmap_filter_unit.sv */
// Top level of the command hash bitmap filter.
// Depends on chbf_pkg and the channel interfaces in chbf_if.sv.
//
// Usage:
//   item_i carries one name character per item (action, char_code, name_end,
//   dir_index). A running hash of the name is kept; on the character with
//   name_end set, the final bitmap index folds in dir_index. Insert sets that
//   bit, query returns one result item on result_o, clear empties the bitmap.
//   cfg_we_i/cfg_wdata_i write hash_enable; with it low every query answers 1.
// Throughput: one item per cycle while item_i.ready is high. Characters that
//   end no name touch only the hash register; final characters read a 256 x 32
//   bitmap RAM at acceptance and write back (insert) in the following cycle or
//   pass the answer (query) to the output register unless stalled. A query result
//   drives result_o.valid from the output register, held until result_o.ready.
// Back-to-back accesses to one row are served by forwarding the last write.
// Reset and clear: a valid bit per RAM row, cleared at once, marks rows as
//   empty; no clearing pass is needed and items are taken right after reset.
// Stall: while a result waits on result_o and the next query result is ready
//   in the modify stage, the modify stage holds and item_i.ready drops.
module command_hash_bitmap_filter_unit
  import chbf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  chbf_in_if.sink      item_i,
  chbf_out_if.source   result_o,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);

  // Configuration
  logic hash_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      hash_enable_q <= cfg_wdata_i;
    end
  end

  // Accept stage: hash update and final index
  logic              accept;
  logic              stall_b;
  logic              is_clear, is_insert, is_query;
  logic              mem_op;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [HASH_W-1:0] h_mul, h_sq_mul, c_mul, h_next, idx;
  logic [HASH_W-1:0] char_red, dir_red;

  assign item_i.ready = !stall_b;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    is_clear  = 1'b0;
    is_insert = 1'b0;
    is_query  = 1'b0;
    case (action_e'(item_i.action))
      ACT_CLEAR:  is_clear  = 1'b1;
      ACT_INSERT: is_insert = 1'b1;
      ACT_QUERY:  is_query  = 1'b1;
      default: ;
    endcase
  end

  // Fold h*243*243 + c*243 + d so the final index needs no second serial multiply.
  assign char_red = item_i.char_code[HASH_W-1:0];
  assign dir_red  = HASH_W'(item_i.dir_index & DIR_W'(MAX_DIRS - 1));
  assign h_mul    = HASH_W'(hash_q * HASH_W'(HASH_MUL));
  assign h_sq_mul = HASH_W'(hash_q * HASH_W'(HASH_MUL_SQ));
  assign c_mul    = HASH_W'(char_red * HASH_W'(HASH_MUL));
  assign h_next   = h_mul + char_red;
  assign idx      = h_sq_mul + c_mul + dir_red;

  assign mem_op = item_i.name_end && (is_insert || is_query);

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      if (is_clear) begin
        hash_d = '0;
      end else if (is_insert || is_query) begin
        // drop the hash after the last character of a name
        hash_d = item_i.name_end ? '0 : h_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  // Bitmap RAM: one read at acceptance, one write from the modify stage
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata_q;
  logic              rd_en;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;

  // modify stage registers
  logic              b_valid_q, b_valid_d;
  logic              b_query_q;
  logic [ROW_W-1:0]  b_row_q;
  logic [OFF_W-1:0]  b_off_q;

  assign rd_en = accept && mem_op;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[b_row_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[idx[HASH_W-1:OFF_W]];
    end
  end

  // Row valid bits and last-write forwarding
  logic [ROWS-1:0]   row_valid_q;
  logic              fwd_valid_q;
  logic [ROW_W-1:0]  fwd_row_q;
  logic [WORD_W-1:0] fwd_data_q;
  logic [WORD_W-1:0] cur_word;
  logic              cur_bit;

  always_comb begin
    if (fwd_valid_q && (fwd_row_q == b_row_q)) begin
      cur_word = fwd_data_q;
    end else if (row_valid_q[b_row_q]) begin
      cur_word = rdata_q;
    end else begin
      cur_word = '0;
    end
  end

  assign cur_bit = cur_word[b_off_q];
  assign wr_en   = b_valid_q && !b_query_q;
  assign wr_word = cur_word | (WORD_W'(1) << b_off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (accept && is_clear) begin
      // clear wins over a write still in flight from an older insert
      row_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      row_valid_q[b_row_q] <= 1'b1;
      fwd_valid_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_row_q  <= b_row_q;
      fwd_data_q <= wr_word;
    end
  end

  // Modify stage control
  logic out_valid_q, out_valid_d;
  logic out_bit_q;
  logic out_load;

  assign stall_b   = b_valid_q && b_query_q && out_valid_q && !result_o.ready;
  assign b_valid_d = stall_b ? b_valid_q : rd_en;
  assign out_load  = b_valid_q && b_query_q && !stall_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      b_query_q <= is_query;
      b_row_q   <= idx[HASH_W-1:OFF_W];
      b_off_q   <= idx[OFF_W-1:0];
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bit_q <= hash_enable_q ? cur_bit : 1'b1;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.maybe_present = out_bit_q;

  // Assertions
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(b_valid_q && b_query_q))
    else $error("result raised without a query in the modify stage");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_clear) |=> (row_valid_q == '0) && !fwd_valid_q)
    else $error("clear did not empty the bitmap");

  a_hash_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_op) |=> (hash_q == '0))
    else $error("running hash not restarted after a name");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_b |=> b_valid_q && b_query_q && $stable(b_row_q) && $stable(b_off_q))
    else $error("modify stage moved while stalled");

endmodule
